>>> rtl/core/vvtcp_pkg.sv
// ----------------------------------------------------------------------------
// vvtcp_pkg
// Shared types and constants of the vertex view transform, clip and project
// pipeline.
// ----------------------------------------------------------------------------
package vvtcp_pkg;

  // default coordinate width, sets the saturation range of the outputs
  localparam int COORD_WIDTH_DEFAULT = 32;

  // quotient bits of the projection divider, one per pipeline stage
  localparam int DIV_QBITS = 33;

  // configuration register index
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_RIGHT   = 3'd0,
    CFG_ROW_UP      = 3'd1,
    CFG_ROW_FORWARD = 3'd2,
    CFG_EYE_XY      = 3'd3,
    CFG_EYE_Z       = 3'd4,
    CFG_CANVAS_W    = 3'd5,
    CFG_CANVAS_H    = 3'd6,
    CFG_W_LIMIT     = 3'd7
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [53:0] ROW_RIGHT_RST   = 54'd65536;
  localparam logic [53:0] ROW_UP_RST      = 54'd65536 << 18;
  localparam logic [53:0] ROW_FORWARD_RST = 54'd65536 << 36;
  localparam logic [12:0] CANVAS_W_RST    = 13'd640;
  localparam logic [12:0] CANVAS_H_RST    = 13'd480;
  localparam logic [31:0] W_LIMIT_RST     = 32'd65536;

  // input word
  typedef struct packed {
    logic               func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [4:0]         clip_bits;
    logic               overflow;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic [31:0]        screen_w;
  } out_word_t;

  // fields that ride alongside the divider
  typedef struct packed {
    logic [31:0] cam_x;
    logic [31:0] cam_y;
    logic [31:0] cam_z;
    logic [4:0]  clip_bits;
    logic        overflow;
    logic        neg_x;
    logic        neg_y;
  } side_t;

endpackage

>>> rtl/core/vvtcp_chan_if.sv
// ----------------------------------------------------------------------------
// vvtcp_chan_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface vvtcp_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

>>> rtl/core/vvtcp_div.sv
// ----------------------------------------------------------------------------
// vvtcp_div
// Pipelined restoring divider, one quotient bit per stage. Gives floor(num/den)
// in DIV_QBITS bits and flags quotients that do not fit.
// ----------------------------------------------------------------------------
module vvtcp_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [63:0]                       num,
  input  logic [31:0]                       den,
  output logic [vvtcp_pkg::DIV_QBITS-1:0]   quo,
  output logic                              big
);
  import vvtcp_pkg::*;

  localparam int QB = DIV_QBITS;

  logic [QB-1:0] rem_r  [QB];
  logic [QB-1:0] low_r  [QB];
  logic [QB-1:0] quo_r  [QB];
  logic [31:0]   den_r  [QB];
  logic          big_r  [QB];

  // head: quotient too large when the upper numerator bits reach the divisor
  logic          head_big;
  logic [QB-1:0] head_rem;

  always_comb begin
    head_big = ({1'b0, num[63:QB]} >= {{(QB-32){1'b0}}, den});
    head_rem = head_big ? '0 : {{(2*QB-64){1'b0}}, num[63:QB]};
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [QB-1:0] r_prev;
    logic [QB-1:0] l_prev;
    logic [QB-1:0] q_prev;
    logic [31:0]   d_prev;
    logic          b_prev;
    logic [QB:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_prev = head_rem;
      assign l_prev = num[QB-1:0];
      assign q_prev = '0;
      assign d_prev = den;
      assign b_prev = head_big;
    end else begin : g_next
      assign r_prev = rem_r[k-1];
      assign l_prev = low_r[k-1];
      assign q_prev = quo_r[k-1];
      assign d_prev = den_r[k-1];
      assign b_prev = big_r[k-1];
    end

    // one compare and subtract step
    assign trial = {r_prev, l_prev[QB-1]};
    assign ge    = (trial >= {{(QB+1-32){1'b0}}, d_prev});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? QB'(trial - {{(QB+1-32){1'b0}}, d_prev}) : trial[QB-1:0];
        low_r[k] <= {l_prev[QB-2:0], 1'b0};
        quo_r[k] <= {q_prev[QB-2:0], ge};
        den_r[k] <= d_prev;
        big_r[k] <= b_prev;
      end
    end
  end

  assign quo = quo_r[QB-1];
  assign big = big_r[QB-1];

endmodule

>>> rtl/core/vertex_view_transform_clip_project_core.sv
// ----------------------------------------------------------------------------
// vertex_view_transform_clip_project_core
// View transform, clip coding and perspective projection of one vertex a cycle.
//
//   channel   dir  payload                                    accept
//   in_ch     in   func, point_x/y/z                          valid & ready
//   out_ch    out  cam_x/y/z, clip_bits, overflow, screen_*   valid & ready
//   cfg_*     in   cfg_index, cfg_data                        cfg_we
//
// One vertex enters per cycle while the output is not stalled; the depth is set by
// the bit-per-stage projection dividers. Reset (rst, synchronous) empties the
// pipeline and loads the register defaults. A stalled output freezes all
// stages together, so no word is lost or repeated.
// ----------------------------------------------------------------------------
module vertex_view_transform_clip_project_core #(
  parameter int COORD_WIDTH = vvtcp_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [vvtcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vvtcp_pkg::CFG_DATA_W-1:0] cfg_data,
  vvtcp_chan_if.sink                       in_ch,
  vvtcp_chan_if.source                     out_ch
);
  import vvtcp_pkg::*;

  localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int NSTG  = 6 + DIV_QBITS;
  localparam logic signed [36:0] CAM_HI = 37'((64'sd1 <<< (SAT_W-1)) - 1);
  localparam logic signed [36:0] CAM_LO = -CAM_HI - 37'sd1;
  localparam logic [32:0] Q_HI = 33'((64'd1 << (SAT_W-1)) - 1);
  localparam logic [32:0] Q_LO = 33'(64'd1 << (SAT_W-1));

  // configuration registers
  logic [53:0] row_right, row_up, row_forward;
  logic [63:0] eye_xy;
  logic [31:0] eye_z;
  logic [12:0] scr_width, scr_height;
  logic [31:0] w_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_right     <= ROW_RIGHT_RST;
      row_up        <= ROW_UP_RST;
      row_forward   <= ROW_FORWARD_RST;
      eye_xy        <= '0;
      eye_z         <= '0;
      scr_width     <= CANVAS_W_RST;
      scr_height    <= CANVAS_H_RST;
      w_limit       <= W_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROW_RIGHT:   row_right     <= cfg_data[53:0];
        CFG_ROW_UP:      row_up        <= cfg_data[53:0];
        CFG_ROW_FORWARD: row_forward   <= cfg_data[53:0];
        CFG_EYE_XY:      eye_xy        <= cfg_data;
        CFG_EYE_Z:       eye_z         <= cfg_data[31:0];
        CFG_CANVAS_W:    scr_width     <= cfg_data[12:0];
        CFG_CANVAS_H:    scr_height    <= cfg_data[12:0];
        CFG_W_LIMIT:     w_limit       <= cfg_data[31:0];
        default:         ;
      endcase
    end
  end

  // pipeline advance and valid bits
  logic            en;
  logic [NSTG-1:0] valid_pipe;

  assign en          = ~valid_pipe[NSTG-1] | out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[NSTG-2:0], in_ch.valid};
    end
  end

  // stage 1: translate by view position when func is 0
  logic signed [32:0] t_next [3];
  logic signed [32:0] t_r    [3];

  always_comb begin
    t_next[0] = {in_ch.word.point_x[31], in_ch.word.point_x};
    t_next[1] = {in_ch.word.point_y[31], in_ch.word.point_y};
    t_next[2] = {in_ch.word.point_z[31], in_ch.word.point_z};
    if (!in_ch.word.func) begin
      t_next[0] = t_next[0] - {eye_xy[31], eye_xy[31:0]};
      t_next[1] = t_next[1] - {eye_xy[63], eye_xy[63:32]};
      t_next[2] = t_next[2] - {eye_z[31], eye_z};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_next;
    end
  end

  // stage 2: nine products of the rotation
  logic [53:0]        rows [3];
  logic signed [50:0] prod_r [3][3];

  assign rows[0] = row_right;
  assign rows[1] = row_up;
  assign rows[2] = row_forward;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= t_r[c] * $signed(rows[r][18*c +: 18]);
        end
      end
    end
  end

  // stage 3: row sums, round to q16.16 and saturate
  logic signed [52:0] dot_sum [3];
  logic signed [52:0] dot_shr [3];
  logic signed [36:0] dot_val [3];
  logic [31:0]        cam_r   [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dot_sum[r] = 53'(prod_r[r][0]) + 53'(prod_r[r][1]) + 53'(prod_r[r][2])
                   + 53'sd32768;
      dot_shr[r] = dot_sum[r] >>> 16;
      dot_val[r] = dot_shr[r][36:0];
      if (dot_val[r] > CAM_HI) begin
        dot_val[r] = CAM_HI;
      end else if (dot_val[r] < CAM_LO) begin
        dot_val[r] = CAM_LO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cam_r[r] <= dot_val[r][31:0];
      end
    end
  end

  // stage 4: clip codes and canvas products
  logic signed [32:0] cx, cy, cz;
  logic signed [46:0] px_r, py_r;
  logic [31:0]        cam4_r [3];
  logic [4:0]         clip4_r;
  logic               ovf4_r;

  assign cx = {cam_r[0][31], cam_r[0]};
  assign cy = {cam_r[1][31], cam_r[1]};
  assign cz = {cam_r[2][31], cam_r[2]};

  always_ff @(posedge clk) begin
    if (en) begin
      cam4_r     <= cam_r;
      clip4_r[0] <= cx > cz;
      clip4_r[1] <= cx < -cz;
      clip4_r[2] <= cy > cz;
      clip4_r[3] <= cy < -cz;
      clip4_r[4] <= cz < 0;
      ovf4_r     <= cz <= 0;
      px_r       <= $signed({1'b0, scr_width}) * (cz + cx);
      py_r       <= $signed({1'b0, scr_height}) * (cz - cy);
    end
  end

  // stage 5: divider operands, negative numerators folded for floor
  logic signed [63:0] nx, ny;
  logic [31:0]        den;
  logic [63:0]        mx_r, my_r, mw_r;
  logic [31:0]        den_r;
  side_t              side5_r;

  always_comb begin
    den = {cam4_r[2][30:0], 1'b0};
    nx  = {px_r[46], px_r, 16'b0} + {{32{cam4_r[2][31]}}, cam4_r[2]};
    ny  = {py_r[46], py_r, 16'b0} + {{32{cam4_r[2][31]}}, cam4_r[2]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r              <= nx[63] ? ~nx + {32'b0, den} : nx;
      my_r              <= ny[63] ? ~ny + {32'b0, den} : ny;
      mw_r              <= (64'd1 << 33) + {32'b0, cam4_r[2]};
      den_r             <= den;
      side5_r.cam_x     <= cam4_r[0];
      side5_r.cam_y     <= cam4_r[1];
      side5_r.cam_z     <= cam4_r[2];
      side5_r.clip_bits <= clip4_r;
      side5_r.overflow  <= ovf4_r;
      side5_r.neg_x     <= nx[63];
      side5_r.neg_y     <= ny[63];
    end
  end

  // dividers for screen x, screen y and reciprocal depth
  logic [DIV_QBITS-1:0] qx, qy, qw;
  logic                 bx, by, bw;

  vvtcp_div u_div_x (.clk, .en, .num(mx_r), .den(den_r), .quo(qx), .big(bx));
  vvtcp_div u_div_y (.clk, .en, .num(my_r), .den(den_r), .quo(qy), .big(by));
  vvtcp_div u_div_w (.clk, .en, .num(mw_r), .den(den_r), .quo(qw), .big(bw));

  // side fields delayed to match the dividers
  side_t side_pipe [DIV_QBITS];

  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe[0] <= side5_r;
      for (int i = 1; i < DIV_QBITS; i++) begin
        side_pipe[i] <= side_pipe[i-1];
      end
    end
  end

  // signed saturation of a quotient
  function automatic logic [31:0] quo_sat(input logic [32:0] q, input logic big,
                                          input logic neg);
    logic [33:0] mag;
    if (!neg) begin
      mag = (big || q > Q_HI) ? {1'b0, Q_HI} : {1'b0, q};
    end else begin
      mag = 34'd0 - ((big || q > Q_LO) ? {1'b0, Q_LO} : {1'b0, q});
    end
    return mag[31:0];
  endfunction

  // output stage
  side_t     side_d;
  out_word_t out_next;
  out_word_t out_r;

  assign side_d = side_pipe[DIV_QBITS-1];

  always_comb begin
    out_next.cam_x     = side_d.cam_x;
    out_next.cam_y     = side_d.cam_y;
    out_next.cam_z     = side_d.cam_z;
    out_next.clip_bits = side_d.clip_bits;
    out_next.overflow  = side_d.overflow;
    if (side_d.overflow) begin
      out_next.screen_x = '0;
      out_next.screen_y = '0;
      out_next.screen_w = '0;
    end else begin
      out_next.screen_x = quo_sat(qx, bx, side_d.neg_x);
      out_next.screen_y = quo_sat(qy, by, side_d.neg_y);
      out_next.screen_w = (bw || qw > {1'b0, w_limit}) ? w_limit : qw[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_next;
    end
  end

  assign out_ch.valid = valid_pipe[NSTG-1];
  assign out_ch.word  = out_r;

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> valid_pipe[0])
    else $error("accepted word did not enter the pipeline");

  a_behind_ovf: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.word.clip_bits[4] |-> out_ch.word.overflow)
    else $error("point behind the eye without overflow");

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.word.overflow |->
      out_ch.word.screen_w == 0 && out_ch.word.screen_x == 0)
    else $error("screen outputs not cleared on overflow");

  a_w_clamp: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.word.screen_w <= w_limit)
    else $error("reciprocal depth above its limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(valid_pipe))
    else $error("pipeline moved during a stall");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the vertex view transform, clip and project core: random and
// directed vertices through several register settings, every result word
// checked field by field against a fixed-point prediction of the transform.
// ----------------------------------------------------------------------------
module tb_top;
  import vvtcp_pkg::*;

  localparam int LATENCY = 39;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vvtcp_chan_if #(.word_t(in_word_t)) in_ch ();
  vvtcp_chan_if #(.word_t(out_word_t)) out_ch ();

  vertex_view_transform_clip_project_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // view state held by the predictor
  logic [53:0] m_right, m_up, m_fwd;
  logic [63:0] eye_xy;
  logic [31:0] eye_z, w_lim;
  logic [12:0] cw, ch;

  in_word_t  vert_q[$];
  out_word_t proj_q[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;
  bit stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round to nearest, ties up; den > 0
  function automatic logic signed [63:0] div_round(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
    logic signed [63:0] n, d;
    n = 2 * num + den;
    d = 2 * den;
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic logic signed [63:0] rotate_row(input logic [53:0] row,
      input logic signed [63:0] tx, ty, tz);
    logic signed [63:0] s;
    s = tx * 64'($signed(row[17:0])) + ty * 64'($signed(row[35:18]))
      + tz * 64'($signed(row[53:36])) + 64'sd32768;
    return sat32(s >>> 16);
  endfunction

  function automatic out_word_t project_vertex(input in_word_t v);
    out_word_t r;
    logic signed [63:0] tx, ty, tz, x, y, z, sx, sy;
    logic [63:0] sw;
    tx = 64'(v.point_x);
    ty = 64'(v.point_y);
    tz = 64'(v.point_z);
    if (!v.func) begin
      tx -= 64'($signed(eye_xy[31:0]));
      ty -= 64'($signed(eye_xy[63:32]));
      tz -= 64'($signed(eye_z));
    end
    x = rotate_row(m_right, tx, ty, tz);
    y = rotate_row(m_up, tx, ty, tz);
    z = rotate_row(m_fwd, tx, ty, tz);
    r = '0;
    r.cam_x = x[31:0];
    r.cam_y = y[31:0];
    r.cam_z = z[31:0];
    r.clip_bits = {z < 0, y < -z, y > z, x < -z, x > z};
    if (z <= 0) begin
      r.overflow = 1'b1;
    end else begin
      sx = sat32(div_round(64'(cw) * 32768 * (z + x), z));
      sy = sat32(div_round(64'(ch) * 32768 * (z - y), z));
      r.screen_x = sx[31:0];
      r.screen_y = sy[31:0];
      sw = ((64'd1 << 33) + 64'(z)) / (64'd2 * 64'(z));
      if (sw > 64'(w_lim)) sw = 64'(w_lim);
      r.screen_w = sw[31:0];
    end
    return r;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROW_RIGHT:   m_right = val[53:0];
      CFG_ROW_UP:      m_up = val[53:0];
      CFG_ROW_FORWARD: m_fwd = val[53:0];
      CFG_EYE_XY:      eye_xy = val;
      CFG_EYE_Z:       eye_z = val[31:0];
      CFG_CANVAS_W:    cw = val[12:0];
      CFG_CANVAS_H:    ch = val[12:0];
      default:         w_lim = val[31:0];
    endcase
  endtask

  // wait for the pipeline to drain before touching the registers
  task automatic drain();
    while (vert_q.size() != 0 || proj_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2097152)) - 1048576) <<< 4;
      2: return {$urandom} >> $urandom_range(0, 31);
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic push_vertex(input logic f, input logic [31:0] px, py, pz);
    in_word_t v;
    v.func = f;
    v.point_x = px;
    v.point_y = py;
    v.point_z = pz;
    vert_q.push_back(v);
  endtask

  // random batch, mostly points in a plausible world box
  task automatic random_batch(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0)
        push_vertex(1'($urandom), rand_coord(1), rand_coord(1), rand_coord(1));
      else
        push_vertex(1'($urandom), rand_coord($urandom_range(0, 3)),
                    rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)));
    end
  endtask

  function automatic logic [53:0] rand_row();
    return 54'({$urandom, $urandom});
  endfunction

  initial begin
    m_right = ROW_RIGHT_RST;
    m_up = ROW_UP_RST;
    m_fwd = ROW_FORWARD_RST;
    eye_xy = '0;
    eye_z = '0;
    cw = CANVAS_W_RST;
    ch = CANVAS_H_RST;
    w_lim = W_LIMIT_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, both modes, behind / on-plane / tiny and huge depth
    push_vertex(1'b0, 32'h0, 32'h0, 32'h0);
    push_vertex(1'b1, 32'h0, 32'h0, 32'h1);
    push_vertex(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_vertex(1'b1, 32'h80000000, 32'h80000000, 32'h80000000);
    push_vertex(1'b0, 32'h7fffffff, 32'h80000000, 32'h00010000);
    push_vertex(1'b1, 32'hffff0000, 32'h00010000, 32'hffff0000);
    push_vertex(1'b0, 32'h00020000, 32'hfffe0000, 32'h00010000);
    push_vertex(1'b1, 32'h00008000, 32'h00008000, 32'h00000002);
    push_vertex(1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    push_vertex(1'b1, 32'h00050000, 32'h00050000, 32'h00050000);
    push_vertex(1'b0, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
    push_vertex(1'b1, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    random_batch(150);
    drain();

    // extreme matrix, eye and canvas; legacy w clamp
    write_reg(CFG_ROW_RIGHT, 64'h1ffff_20000_1ffff);
    write_reg(CFG_ROW_UP, 64'h20000_1ffff_20000);
    write_reg(CFG_ROW_FORWARD, 64'h1ffff_1ffff_1ffff);
    write_reg(CFG_EYE_XY, 64'h80000000_7fffffff);
    write_reg(CFG_EYE_Z, 64'h80000000);
    write_reg(CFG_CANVAS_W, 64'd4096);
    write_reg(CFG_CANVAS_H, 64'd1);
    write_reg(CFG_W_LIMIT, 64'd4026466304);
    push_vertex(1'b0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push_vertex(1'b1, 32'h00000001, 32'h00000001, 32'h00000001);
    random_batch(150);
    drain();

    // out-of-range canvas and limit raw values
    write_reg(CFG_CANVAS_W, 64'h1fff);
    write_reg(CFG_CANVAS_H, 64'h0);
    write_reg(CFG_W_LIMIT, 64'hffffffff);
    write_reg(CFG_EYE_XY, 64'h7fffffff_80000000);
    write_reg(CFG_EYE_Z, 64'h7fffffff);
    random_batch(100);
    drain();
    write_reg(CFG_W_LIMIT, 64'h0);
    write_reg(CFG_CANVAS_W, 64'd1);
    write_reg(CFG_CANVAS_H, 64'd4096);
    random_batch(100);
    drain();

    // random settings, small rotation near identity plus full random
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_ROW_RIGHT,
                64'(p[0] ? rand_row() : 54'(32'($urandom_range(0, 131071)))));
      write_reg(CFG_ROW_UP, 64'(rand_row()));
      write_reg(CFG_ROW_FORWARD,
                64'(p[1] ? rand_row() : (54'h10000 << 36) | 54'($urandom & 16'hffff)));
      write_reg(CFG_EYE_XY, {rand_coord(1), rand_coord(1)});
      write_reg(CFG_EYE_Z, 64'(rand_coord(1)));
      write_reg(CFG_CANVAS_W, 64'($urandom_range(1, 4096)));
      write_reg(CFG_CANVAS_H, 64'($urandom_range(1, 4096)));
      write_reg(CFG_W_LIMIT, $urandom_range(0, 1) ? 64'd65536 : 64'd4026466304);
      random_batch(100);
      drain();
    end
    stim_done = 1'b1;
  end

  // ready sampled at the rising edge so acceptance is captured after the edge
  logic acc_in;
  always @(posedge clk) acc_in <= in_ch.valid && in_ch.ready;

  // sender: drives words from the vertex queue with random idle gaps, none in burst mode
  int gap = 0;
  bit burst = 1'b0;
  in_word_t cur;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.word <= '0;
    end else if (in_ch.valid && !acc_in) begin
      // hold word
    end else begin
      if (acc_in) begin
        proj_q.push_back(project_vertex(cur));
        void'(vert_q.pop_front());
        gap = burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0) burst = !burst;
      end
      if (gap > 0) begin
        gap--;
        in_ch.valid <= 1'b0;
      end else if (vert_q.size() != 0) begin
        cur = vert_q[0];
        in_ch.valid <= 1'b1;
        in_ch.word <= cur;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to fill the pipe
  int stall = 0;
  bit long_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (!long_done && cycles > 600) begin
      long_done <= 1'b1;
      hold_off <= 150;
      out_ch.ready <= 1'b0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready && !burst) stall <= $urandom_range(0, 7);
    end
  end

  // monitor: compare each accepted result word against the oldest prediction
  always @(posedge clk) begin
    out_word_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.word;
      if (proj_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = proj_q.pop_front();
        if (got.cam_x !== want.cam_x || got.cam_y !== want.cam_y ||
            got.cam_z !== want.cam_z || got.clip_bits !== want.clip_bits ||
            got.overflow !== want.overflow || got.screen_x !== want.screen_x ||
            got.screen_y !== want.screen_y || got.screen_w !== want.screen_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && proj_q.size() == 0 && vert_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
